// ===== design/ternary_binary_matmul_popcount_defines.svh =====
// Assertion macros for the ternary-binary matmul block.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef TERNARY_BINARY_MATMUL_POPCOUNT_DEFINES_SVH
`define TERNARY_BINARY_MATMUL_POPCOUNT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBMP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbmp assertion failed");
`define TBMP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbmp assertion failed");
`else
`define TBMP_ASSERT_IMP(label, clk, rst, ante, cons)
`define TBMP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/tbmp_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the ternary-binary matmul block. No dependencies.
package tbmp_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_WORDS   = 16;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int WORD_W      = $clog2(MAX_WORDS);
  localparam int ADDR_W      = ROW_W + WORD_W;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_WORDS;
  localparam int DATA_W      = 64;
  localparam int COL_W       = 12;
  localparam int ACC_W       = 12;
  localparam int CNT_W       = $clog2(DATA_W + 1);
  localparam int RIU_W       = 7;
  localparam int RIU_RESET   = 64;

  typedef enum logic {
    KIND_A_LOAD = 1'b0,
    KIND_B_WORD = 1'b1
  } kind_t;

  typedef struct packed {
    logic             load_we;
    logic             capture;
    logic             scan_rd;
    logic             emit;
    logic             emit_last;
    logic             clear;
    logic [ROW_W-1:0] row_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== design/ternary_binary_matmul_popcount.sv =====
// Top level of the ternary-by-binary matmul popcount block.
// Depends on tbmp_pkg, tbmp_ctrl, tbmp_datapath and the defines header.
//
// Usage:
//   Items are transferred with start while busy is low. kind 0 loads one
//   A word pair (plus and minus plane) at row/word and busy stays low.
//   kind 1 brings one B column word; the block then reads the stored A
//   words of all 64 rows for that word index, one row per cycle from the
//   plane RAMs, through a three-stage read/popcount/accumulate pipeline;
//   busy stays high until the pipeline has drained. On a word with column_end
//   set, the block then emits one result per row in use (rows_in_use,
//   clamped to 64), one per cycle with valid high, last on the final one,
//   and then clears the accumulators; busy stays high through both. The
//   row scan over the single RAM read port sets the rate.
//   Results cannot be stalled; each is valid for exactly one cycle.
//   rows_in_use is written through cfg_we/cfg_wdata, by the user only while
//   the block is idle; the block itself does not enforce this.
//   Reset (synchronous) clears the accumulators, sets rows_in_use to 64 and
//   returns the controller to idle; the A stores hold garbage until loaded.
`include "ternary_binary_matmul_popcount_defines.svh"
module ternary_binary_matmul_popcount (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind,
  input  logic [tbmp_pkg::ROW_W-1:0]         row,
  input  logic [tbmp_pkg::WORD_W-1:0]        word,
  input  logic [tbmp_pkg::DATA_W-1:0]        a_plus_word,
  input  logic [tbmp_pkg::DATA_W-1:0]        a_minus_word,
  input  logic [tbmp_pkg::DATA_W-1:0]        b_word,
  input  logic [tbmp_pkg::COL_W-1:0]         column,
  input  logic                               column_end,
  input  logic                               cfg_we,
  input  logic [tbmp_pkg::RIU_W-1:0]         cfg_wdata,
  output logic                               valid,
  output logic [tbmp_pkg::ROW_W-1:0]         out_row,
  output logic [tbmp_pkg::COL_W-1:0]         out_column,
  output logic signed [tbmp_pkg::ACC_W-1:0]  value,
  output logic                               last
);

  tbmp_pkg::ctrl_cmd_t  cmd;
  tbmp_pkg::dp_status_t status;

  tbmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .row       (row),
    .word      (word),
    .column_end(column_end),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  tbmp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .row         (row),
    .word        (word),
    .a_plus_word (a_plus_word),
    .a_minus_word(a_minus_word),
    .b_word      (b_word),
    .column      (column),
    .status      (status),
    .valid       (valid),
    .out_row     (out_row),
    .out_column  (out_column),
    .value       (value),
    .last        (last)
  );

  `TBMP_ASSERT_IMP(a_valid_while_busy, clk, rst, valid, busy)
  `TBMP_ASSERT_NXT(a_last_ends_burst, clk, rst, valid && last, !valid)
  `TBMP_ASSERT_NXT(a_burst_contiguous, clk, rst, valid && !last, valid)
  `TBMP_ASSERT_NXT(a_bword_busy, clk, rst, start && !busy && kind, busy)

endmodule

// ===== design/tbmp_ram.sv =====
// Generic dual-port RAM: one write port and one read port with registered read.
// No dependencies.
module tbmp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tbmp_ctrl.sv =====
// Controller: sequences loads, row scans, pipeline drain, result emission
// and accumulator clear. Depends on tbmp_pkg.
module tbmp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          kind,
  input  logic [tbmp_pkg::ROW_W-1:0]    row,
  input  logic [tbmp_pkg::WORD_W-1:0]   word,
  input  logic                          column_end,
  input  logic                          cfg_we,
  input  logic [tbmp_pkg::RIU_W-1:0]    cfg_wdata,
  input  tbmp_pkg::dp_status_t          status,
  output logic                          busy,
  output tbmp_pkg::ctrl_cmd_t           cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  state_t                          state;
  logic [tbmp_pkg::ROW_W-1:0]      cnt;
  logic                            end_q;
  logic [tbmp_pkg::RIU_W-1:0]      rows_in_use;
  logic [tbmp_pkg::RIU_W-1:0]      eff;
  logic                            accept;
  logic                            emit_last;
  logic                            load_ok;
  logic                            word_ok;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && (state == ST_IDLE);
  assign load_ok = (32'(row) < tbmp_pkg::MAX_ROWS) && (32'(word) < tbmp_pkg::MAX_WORDS);
  assign word_ok = (32'(word) < tbmp_pkg::MAX_WORDS);
  assign eff     = (rows_in_use > tbmp_pkg::RIU_W'(tbmp_pkg::MAX_ROWS))
                   ? tbmp_pkg::RIU_W'(tbmp_pkg::MAX_ROWS) : rows_in_use;
  assign emit_last = ({1'b0, cnt} == eff - tbmp_pkg::RIU_W'(1));

  always_comb begin
    cmd           = '0;
    cmd.load_we   = accept && (kind == tbmp_pkg::KIND_A_LOAD) && load_ok;
    cmd.capture   = accept;
    cmd.scan_rd   = (state == ST_SCAN);
    cmd.emit      = (state == ST_EMIT);
    cmd.emit_last = (state == ST_EMIT) && emit_last;
    cmd.clear     = (state == ST_CLEAR);
    cmd.row_idx   = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      end_q       <= 1'b0;
      rows_in_use <= tbmp_pkg::RIU_W'(tbmp_pkg::RIU_RESET);
    end else begin
      if (cfg_we) begin
        rows_in_use <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (kind == tbmp_pkg::KIND_B_WORD)) begin
            end_q <= column_end;
            cnt   <= '0;
            state <= word_ok ? ST_SCAN : ST_DRAIN;
          end
        end
        ST_SCAN: begin
          if (cnt == tbmp_pkg::ROW_W'(tbmp_pkg::MAX_ROWS - 1)) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + tbmp_pkg::ROW_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!status.pipe_busy) begin
            cnt <= '0;
            if (!end_q) begin
              state <= ST_IDLE;
            end else if (eff == '0) begin
              state <= ST_CLEAR;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          cnt <= cnt + tbmp_pkg::ROW_W'(1);
          if (emit_last) begin
            state <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/tbmp_datapath.sv =====
// Datapath: A plane stores, popcount pipeline, row accumulators and
// result register. Depends on tbmp_pkg and tbmp_ram.
module tbmp_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  tbmp_pkg::ctrl_cmd_t                cmd,
  input  logic [tbmp_pkg::ROW_W-1:0]         row,
  input  logic [tbmp_pkg::WORD_W-1:0]        word,
  input  logic [tbmp_pkg::DATA_W-1:0]        a_plus_word,
  input  logic [tbmp_pkg::DATA_W-1:0]        a_minus_word,
  input  logic [tbmp_pkg::DATA_W-1:0]        b_word,
  input  logic [tbmp_pkg::COL_W-1:0]         column,
  output tbmp_pkg::dp_status_t               status,
  output logic                               valid,
  output logic [tbmp_pkg::ROW_W-1:0]         out_row,
  output logic [tbmp_pkg::COL_W-1:0]         out_column,
  output logic signed [tbmp_pkg::ACC_W-1:0]  value,
  output logic                               last
);

  function automatic logic [tbmp_pkg::CNT_W-1:0] pop64(input logic [63:0] v);
    logic [3:0]                  part [8];
    logic [tbmp_pkg::CNT_W-1:0]  total;
    for (int j = 0; j < 8; j++) begin
      part[j] = '0;
      for (int k = 0; k < 8; k++) begin
        part[j] = part[j] + 4'(v[8*j+k]);
      end
    end
    total = '0;
    for (int j = 0; j < 8; j++) begin
      total = total + tbmp_pkg::CNT_W'(part[j]);
    end
    return total;
  endfunction

  logic [tbmp_pkg::WORD_W-1:0]   word_q;
  logic [tbmp_pkg::DATA_W-1:0]   b_q;
  logic [tbmp_pkg::COL_W-1:0]    column_q;
  logic [tbmp_pkg::ADDR_W-1:0]   wr_addr;
  logic [tbmp_pkg::ADDR_W-1:0]   rd_addr;
  logic [tbmp_pkg::DATA_W-1:0]   plus_rd;
  logic [tbmp_pkg::DATA_W-1:0]   minus_rd;
  logic                          v1;
  logic                          v2;
  logic [tbmp_pkg::ROW_W-1:0]    row_d1;
  logic [tbmp_pkg::ROW_W-1:0]    row_d2;
  logic [tbmp_pkg::DATA_W-1:0]   pos;
  logic [tbmp_pkg::DATA_W-1:0]   neg;
  logic [tbmp_pkg::CNT_W-1:0]    pc_pos;
  logic [tbmp_pkg::CNT_W-1:0]    pc_neg;
  logic                          acc_re;
  logic [tbmp_pkg::ROW_W-1:0]    acc_raddr;
  logic [tbmp_pkg::ACC_W-1:0]    acc_rdata;
  logic                          acc_cleared;
  logic [tbmp_pkg::ACC_W-1:0]    acc_rd;
  logic [tbmp_pkg::ACC_W:0]      sum;
  logic [tbmp_pkg::ACC_W-1:0]    acc_next;

  assign wr_addr = {row, word};
  assign rd_addr = {cmd.row_idx, word_q};

  tbmp_ram #(
    .WIDTH(tbmp_pkg::DATA_W),
    .DEPTH(tbmp_pkg::STORE_DEPTH)
  ) u_plus_ram (
    .clk  (clk),
    .we   (cmd.load_we),
    .waddr(wr_addr),
    .wdata(a_plus_word),
    .re   (cmd.scan_rd),
    .raddr(rd_addr),
    .rdata(plus_rd)
  );

  tbmp_ram #(
    .WIDTH(tbmp_pkg::DATA_W),
    .DEPTH(tbmp_pkg::STORE_DEPTH)
  ) u_minus_ram (
    .clk  (clk),
    .we   (cmd.load_we),
    .waddr(wr_addr),
    .wdata(a_minus_word),
    .re   (cmd.scan_rd),
    .raddr(rd_addr),
    .rdata(minus_rd)
  );

  assign pos = (plus_rd | b_q) & (minus_rd | ~b_q);
  assign neg = (plus_rd | ~b_q) & (minus_rd | b_q);

  assign acc_re    = v1 || cmd.emit;
  assign acc_raddr = cmd.emit ? cmd.row_idx : row_d1;

  tbmp_ram #(
    .WIDTH(tbmp_pkg::ACC_W),
    .DEPTH(tbmp_pkg::MAX_ROWS)
  ) u_acc_ram (
    .clk  (clk),
    .we   (v2),
    .waddr(row_d2),
    .wdata(acc_next),
    .re   (acc_re),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // read every row as zero until the next scan has rewritten all of them
  assign acc_rd = acc_cleared ? '0 : acc_rdata;
  assign sum    = {acc_rd[tbmp_pkg::ACC_W-1], acc_rd}
                  + (tbmp_pkg::ACC_W+1)'(pc_pos) - (tbmp_pkg::ACC_W+1)'(pc_neg);

  // saturate on signed overflow of the accumulator width
  always_comb begin
    if (!sum[tbmp_pkg::ACC_W] && sum[tbmp_pkg::ACC_W-1]) begin
      acc_next = {1'b0, {(tbmp_pkg::ACC_W-1){1'b1}}};
    end else if (sum[tbmp_pkg::ACC_W] && !sum[tbmp_pkg::ACC_W-1]) begin
      acc_next = {1'b1, {(tbmp_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_next = sum[tbmp_pkg::ACC_W-1:0];
    end
  end

  assign status.pipe_busy = v1 || v2;
  assign value            = acc_rd;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_q   <= word;
      b_q      <= b_word;
      column_q <= column;
    end
    row_d1     <= cmd.row_idx;
    row_d2     <= row_d1;
    pc_pos     <= pop64(pos);
    pc_neg     <= pop64(neg);
    out_row    <= cmd.row_idx;
    out_column <= column_q;
    last       <= cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= cmd.scan_rd;
      v2    <= v1;
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      acc_cleared <= 1'b1;
    end else if (v2 && (row_d2 == tbmp_pkg::ROW_W'(tbmp_pkg::MAX_ROWS - 1))) begin
      acc_cleared <= 1'b0;
    end
  end

endmodule

// ===== tb/tb_ternary_binary_matmul_popcount.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ternary_binary_matmul_popcount: directed table, then
// random A loads and B columns checked against a dot-product predictor.
// Depends on tbmp_pkg and the block.
module tb_ternary_binary_matmul_popcount;
  import tbmp_pkg::*;

  localparam int PLAN_LEN      = 20;
  localparam int RANDOM_ITEMS  = 100;
  localparam int SETTLE_CYCLES = 140;
  localparam int LIMIT_CYCLES  = 500000;
  localparam logic [DATA_W-1:0] ONES = '1;
  localparam logic [DATA_W-1:0] ZERO = '0;

  typedef enum int {STEP_CFG, STEP_LOAD, STEP_FILL, STEP_BWORD} step_op_t;

  typedef struct {
    step_op_t          op;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] ap;
    logic [DATA_W-1:0] am;
    logic [DATA_W-1:0] b;
    logic [COL_W-1:0]  column;
    logic              col_end;
    int                reps;
    bit                typed;
    int                typed_value;
    logic [RIU_W-1:0]  cfg;
  } step_t;

  typedef struct {
    kind_t             kind;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] a_plus;
    logic [DATA_W-1:0] a_minus;
    logic [DATA_W-1:0] b;
    logic [COL_W-1:0]  column;
    logic              col_end;
  } item_t;

  typedef struct {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } product_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    kind = 1'b0;
  logic [ROW_W-1:0]        row = '0;
  logic [WORD_W-1:0]       word = '0;
  logic [DATA_W-1:0]       a_plus_word = '0;
  logic [DATA_W-1:0]       a_minus_word = '0;
  logic [DATA_W-1:0]       b_word = '0;
  logic [COL_W-1:0]        column = '0;
  logic                    column_end = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [RIU_W-1:0]        cfg_wdata = '0;
  logic                    valid;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_column;
  logic signed [ACC_W-1:0] value;
  logic                    last;

  logic [DATA_W-1:0] plus_plane [STORE_DEPTH];
  logic [DATA_W-1:0] minus_plane [STORE_DEPTH];
  bit                loaded [MAX_ROWS][MAX_WORDS];
  int                row_acc [MAX_ROWS];
  logic [RIU_W-1:0]  rows_cfg = RIU_W'(RIU_RESET);
  product_t          pending_products [$];
  step_t             plan [PLAN_LEN];
  int                mismatches = 0;
  int                cycles = 0;
  int                random_items = 0;
  bit                steady = 1'b0;

  ternary_binary_matmul_popcount uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .row          (row),
    .word         (word),
    .a_plus_word  (a_plus_word),
    .a_minus_word (a_minus_word),
    .b_word       (b_word),
    .column       (column),
    .column_end   (column_end),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .valid        (valid),
    .out_row      (out_row),
    .out_column   (out_column),
    .value        (value),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] pattern64();
    case ($urandom_range(0, 5))
      0: return ZERO;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void predict_dot_products(input item_t it, input bit typed,
                                               input int typed_value);
    int idx;
    int acc;
    int n;
    logic [DATA_W-1:0] p, m, pos, neg;
    product_t r;
    if (it.kind == KIND_A_LOAD) begin
      idx = int'(it.row) * MAX_WORDS + int'(it.word);
      plus_plane[idx] = it.a_plus;
      minus_plane[idx] = it.a_minus;
      loaded[it.row][it.word] = 1'b1;
    end else begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        idx = i * MAX_WORDS + int'(it.word);
        p = plus_plane[idx];
        m = minus_plane[idx];
        pos = (p | it.b) & (m | ~it.b);
        neg = (p | ~it.b) & (m | it.b);
        acc = row_acc[i] + $countones(pos) - $countones(neg);
        if (acc > 2047) acc = 2047;
        if (acc < -2048) acc = -2048;
        row_acc[i] = acc;
      end
      if (it.col_end) begin
        n = (int'(rows_cfg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
        for (int i = 0; i < n; i++) begin
          r.row = ROW_W'(i);
          r.column = it.column;
          r.value = typed ? ACC_W'(typed_value) : ACC_W'(row_acc[i]);
          r.last = (i == n - 1);
          pending_products.push_back(r);
        end
        for (int i = 0; i < MAX_ROWS; i++) row_acc[i] = 0;
      end
    end
  endfunction

  task automatic transfer_item(input item_t it, input bit typed, input int typed_value);
    int gap;
    if ($urandom_range(0, 15) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = it.kind;
    row = it.row;
    word = it.word;
    a_plus_word = it.a_plus;
    a_minus_word = it.a_minus;
    b_word = it.b;
    column = it.column;
    column_end = it.col_end;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_dot_products(it, typed, typed_value);
  endtask

  task automatic write_rows_in_use(input logic [RIU_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending_products.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(posedge clk);
    rows_cfg = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // load every row at one word index, fixed or random planes
  task automatic fill_word(input logic [WORD_W-1:0] w, input bit scramble,
                           input logic [DATA_W-1:0] ap, input logic [DATA_W-1:0] am);
    item_t it;
    for (int r = 0; r < MAX_ROWS; r++) begin
      it = '{KIND_A_LOAD, ROW_W'(r), w, ap, am, pattern64(), COL_W'($urandom),
             1'($urandom)};
      if (scramble) begin
        it.a_plus = pattern64();
        it.a_minus = ($urandom_range(0, 2) == 0) ? pattern64() : pattern64() & ~it.a_plus;
      end
      transfer_item(it, 1'b0, 0);
    end
  endtask

  always @(posedge clk) begin : check_products
    product_t want;
    if (!rst && valid) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected result row %0d column %0d value %0d last %0b", $time,
                 out_row, out_column, value, last);
        mismatches++;
      end else begin
        want = pending_products.pop_front();
        if (out_row !== want.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, want.row, out_row);
          mismatches++;
        end
        if (out_column !== want.column) begin
          $display("%0t: out_column expected %0d actual %0d", $time, want.column, out_column);
          mismatches++;
        end
        if (value !== want.value) begin
          $display("%0t: value row %0d expected %0d actual %0d", $time, want.row,
                   want.value, value);
          mismatches++;
        end
        if (last !== want.last) begin
          $display("%0t: last row %0d expected %0b actual %0b", $time, want.row,
                   want.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    step_t            s;
    item_t            it;
    int               ready [$];
    int               len;
    bit               complete;
    logic [RIU_W-1:0] riu;

    for (int i = 0; i < MAX_ROWS; i++) row_acc[i] = 0;
    plan = '{
      '{STEP_CFG,   0,  0, ZERO, ZERO, ZERO, 0,    1'b0, 1,  1'b0, 0,     7'd64},
      '{STEP_FILL,  0,  0, ONES, ZERO, ZERO, 0,    1'b0, 1,  1'b0, 0,     7'd0},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ZERO, 0,    1'b1, 1,  1'b1, 64,    7'd0},
      '{STEP_BWORD, 63, 0, ONES, ONES, ONES, 4095, 1'b1, 1,  1'b1, -64,   7'd0},
      '{STEP_FILL,  0,  15, ZERO, ONES, ZERO, 0,   1'b0, 1,  1'b0, 0,     7'd0},
      '{STEP_BWORD, 0,  15, ZERO, ZERO, ONES, 1,   1'b1, 1,  1'b1, 64,    7'd0},
      '{STEP_BWORD, 0,  15, ZERO, ZERO, ZERO, 2,   1'b1, 1,  1'b1, -64,   7'd0},
      // columns longer than the store saturate the accumulators
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ZERO, 7,    1'b1, 33, 1'b1, 2047,  7'd0},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ONES, 8,    1'b1, 33, 1'b1, -2048, 7'd0},
      '{STEP_CFG,   0,  0, ZERO, ZERO, ZERO, 0,    1'b0, 1,  1'b0, 0,     7'd1},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ZERO, 9,    1'b1, 1,  1'b1, 64,    7'd0},
      // zero rows: no result, accumulators still cleared
      '{STEP_CFG,   0,  0, ZERO, ZERO, ZERO, 0,    1'b0, 1,  1'b0, 0,     7'd0},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ZERO, 10,   1'b1, 1,  1'b0, 0,     7'd0},
      '{STEP_CFG,   0,  0, ZERO, ZERO, ZERO, 0,    1'b0, 1,  1'b0, 0,     7'd127},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ZERO, 11,   1'b1, 1,  1'b1, 64,    7'd0},
      '{STEP_LOAD,  5,  0, ZERO, ONES, ONES, 12,   1'b1, 1,  1'b0, 0,     7'd0},
      // both plane bits set counts zero
      '{STEP_LOAD,  9,  0, ONES, ONES, ZERO, 13,   1'b0, 1,  1'b0, 0,     7'd0},
      '{STEP_BWORD, 0,  0, ZERO, ZERO, ONES, 14,   1'b0, 1,  1'b0, 0,     7'd0},
      '{STEP_BWORD, 0,  15, ZERO, ZERO, ONES, 15,  1'b1, 1,  1'b0, 0,     7'd0},
      '{STEP_LOAD,  63, 15, ONES, ZERO, ZERO, 16,  1'b0, 1,  1'b0, 0,     7'd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      s = plan[i];
      case (s.op)
        STEP_CFG: write_rows_in_use(s.cfg);
        STEP_FILL: fill_word(s.word, 1'b0, s.ap, s.am);
        default: begin
          for (int k = 0; k < s.reps; k++) begin
            it = '{(s.op == STEP_LOAD) ? KIND_A_LOAD : KIND_B_WORD, s.row, s.word, s.ap, s.am,
                   s.b, s.column, s.col_end && (k == s.reps - 1)};
            transfer_item(it, s.typed && (k == s.reps - 1), s.typed_value);
          end
        end
      endcase
    end

    fill_word(WORD_W'($urandom_range(1, 14)), 1'b1, ZERO, ZERO);
    random_items += MAX_ROWS;

    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: riu = 7'd0;
          1: riu = 7'd1;
          2: riu = 7'd64;
          3: riu = 7'd127;
          default: riu = RIU_W'($urandom_range(1, 127));
        endcase
        write_rows_in_use(riu);
      end
      repeat ($urandom_range(0, 3)) begin
        it = '{KIND_A_LOAD, ROW_W'($urandom), WORD_W'($urandom), pattern64(), pattern64(),
               pattern64(), COL_W'($urandom), 1'($urandom)};
        transfer_item(it, 1'b0, 0);
        random_items++;
      end
      ready.delete();
      for (int w = 0; w < MAX_WORDS; w++) begin
        complete = 1'b1;
        for (int r = 0; r < MAX_ROWS; r++) if (!loaded[r][w]) complete = 1'b0;
        if (complete) ready.push_back(w);
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          it = '{KIND_A_LOAD, ROW_W'($urandom), WORD_W'(ready[$urandom_range(0, ready.size()-1)]),
                 pattern64(), pattern64(), pattern64(), COL_W'($urandom), 1'($urandom)};
          transfer_item(it, 1'b0, 0);
          random_items++;
        end
        it = '{KIND_B_WORD, ROW_W'($urandom), WORD_W'(ready[$urandom_range(0, ready.size()-1)]),
               pattern64(), pattern64(), pattern64(), COL_W'($urandom), k == len - 1};
        transfer_item(it, 1'b0, 0);
        random_items++;
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tbmp_pkg.sv
design/tbmp_ram.sv
design/tbmp_ctrl.sv
design/tbmp_datapath.sv
design/ternary_binary_matmul_popcount.sv
tb/tb_ternary_binary_matmul_popcount.sv
